>>> hdl/lfpd_pkg.sv
package lfpd_pkg;

    localparam logic [7:0] HDR_A = 8'h03;
    localparam logic [7:0] HDR_B = 8'h08;
    localparam logic [7:0] HDR_C = 8'h4E;

    // byte positions inside a frame
    localparam logic [4:0] POS_HUNT  = 5'd0;
    localparam logic [4:0] POS_HDR_B = 5'd1;
    localparam logic [4:0] POS_SPEED = 5'd2;
    localparam logic [4:0] POS_HDR_C = 5'd3;
    localparam logic [4:0] POS_FIRST = 5'd4;
    localparam logic [4:0] POS_LAST  = 5'd31;

    localparam int FRAME_BYTES  = 32;
    localparam int POINTS       = 8;
    localparam int POINT_BYTES  = 3;
    localparam int POINT_BITS   = POINT_BYTES * 8;
    localparam int PAYLOAD_BITS = POINTS * POINT_BITS;
    localparam int POINT_BASE   = 6;

    localparam int ANGLE_W = 21;
    localparam int STEP_W  = 18;
    localparam int DIST_W  = 16;

    // angle in 1/512 degree = raw*8 - 327680; full turn is 184320, i.e. 23040 raw steps
    localparam logic [ANGLE_W-1:0] ANGLE_OFFSET   = 21'd327680;
    localparam logic [STEP_W-1:0]  TURN_PER_POINT = 18'd23040;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0]   points;
        logic [7:0]                speed;
        logic signed [STEP_W-1:0]  step;
        logic [ANGLE_W-1:0]        start_angle;
    } frame_t;

endpackage

>>> hdl/lidar_frame_point_decoder_top.sv
// Lidar frame point decoder. Takes the serial byte stream one word per cycle while the
// frame queue has room, hunts the 0x03 0x08 <speed> 0x4E header and collects the frame
// body up to byte 31. A completed frame goes into a frame queue (two entries by default);
// the point stage pops it when idle and sends eight point words on consecutive cycles
// while the output is ready (angle in 1/512 degree, distance, quality, speed; tlast on
// the eighth point). A frame is 32 input bytes against eight output words, so the input
// stalls only when the frame queue is full, which takes output backpressure.
module lidar_frame_point_decoder_top #(
    parameter int QUEUE_DEPTH = lfpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lfpd_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [20:0] point_angle, [36:21] point_distance, [44:37] point_quality,
    // [52:45] rotation_speed, [55:53] zero
    output logic [lfpd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast   // last_point
);
    import lfpd_pkg::*;

    frame_t push_frame;
    frame_t head_frame;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;

    lfpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .queue_full (full),
        .push       (push),
        .push_frame (push_frame)
    );

    lfpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_frame (head_frame),
        .empty      (empty),
        .full       (full)
    );

    lfpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_frame (head_frame),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

>>> hdl/lfpd_front.sv
module lfpd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            queue_full,
    output logic                            push,
    output lfpd_pkg::frame_t                push_frame
);
    import lfpd_pkg::*;

    logic [4:0] pos_reg;
    logic [4:0] pos_next;
    logic [7:0] bytes_reg [FRAME_BYTES];
    logic       accept;
    logic [15:0] raw_start;
    logic [15:0] raw_end;
    logic signed [16:0] raw_diff;
    logic signed [STEP_W-1:0] step;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos_next = pos_reg;
        case (pos_reg)
            POS_HUNT:  pos_next = (in_byte == HDR_A) ? POS_HDR_B : POS_HUNT;
            POS_HDR_B: pos_next = (in_byte == HDR_B) ? POS_SPEED : POS_HUNT;
            POS_SPEED: pos_next = POS_HDR_C;
            POS_HDR_C: pos_next = (in_byte == HDR_C) ? POS_FIRST : POS_HUNT;
            POS_LAST:  pos_next = POS_HUNT;
            default:   pos_next = pos_reg + 5'd1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    // store speed and body bytes; the last byte is used straight from the input
    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg == POS_SPEED || pos_reg >= POS_FIRST))
        begin
            bytes_reg[pos_reg] <= in_byte;
        end
    end

    assign raw_start = {bytes_reg[5], bytes_reg[4]};
    assign raw_end   = {in_byte, bytes_reg[30]};
    assign raw_diff  = $signed({1'b0, raw_end}) - $signed({1'b0, raw_start});

    always_comb
    begin
        step = {raw_diff[16], raw_diff};
        if (raw_end < raw_start)
        begin
            step = step + $signed(TURN_PER_POINT);
        end
    end

    always_comb
    begin
        push_frame.start_angle = ANGLE_W'({raw_start, 3'b000}) - ANGLE_OFFSET;
        push_frame.step        = step;
        push_frame.speed       = bytes_reg[POS_SPEED];
        for (int i = 0; i < POINTS * POINT_BYTES; i++)
        begin
            push_frame.points[i*8 +: 8] = bytes_reg[POINT_BASE + i];
        end
    end

    assign push = accept && (pos_reg == POS_LAST);

endmodule

>>> hdl/lfpd_queue.sv
module lfpd_queue #(
    parameter int DEPTH = lfpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lfpd_pkg::frame_t  push_frame,
    input  logic              pop,
    output lfpd_pkg::frame_t  head_frame,
    output logic              empty,
    output logic              full
);
    import lfpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    frame_t            mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_frame = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/lfpd_back.sv
module lfpd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfpd_pkg::frame_t                    head_frame,
    input  logic                                empty,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lfpd_pkg::OUT_TDATA_W-1:0]    out_data,
    output logic                                out_last
);
    import lfpd_pkg::*;

    localparam int K_W = $clog2(POINTS);
    localparam logic [K_W-1:0] K_LAST = K_W'(POINTS - 1);

    logic                       busy_reg;
    logic [K_W-1:0]             k_reg;
    logic [PAYLOAD_BITS-1:0]    points_reg;
    logic [7:0]                 speed_reg;
    logic signed [STEP_W-1:0]   step_reg;
    logic [ANGLE_W-1:0]         angle_reg;
    logic                       valid_reg;
    logic [OUT_TDATA_W-1:0]     data_reg;
    logic                       last_reg;
    logic                       slot_free;
    logic                       emit;

    assign slot_free = !valid_reg || out_ready;
    assign emit      = busy_reg && slot_free;
    assign pop       = !busy_reg && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (emit)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == K_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            points_reg <= head_frame.points;
            speed_reg  <= head_frame.speed;
            step_reg   <= head_frame.step;
            angle_reg  <= head_frame.start_angle;
        end
        else if (emit)
        begin
            // advance to the next point
            points_reg <= points_reg >> POINT_BITS;
            angle_reg  <= angle_reg + ANGLE_W'(step_reg);
        end

        if (emit)
        begin
            data_reg <= {3'b000, speed_reg, points_reg[23:16], points_reg[15:0], angle_reg};
            last_reg <= (k_reg == K_LAST);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

>>> hdl/lfpd_checker.sv
module lfpd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [lfpd_pkg::IN_TDATA_W-1:0]      s_tdata,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [lfpd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input logic                                 m_tlast
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while stalled");

    a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid straight after reset");

    a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> s_tready)
        else $error("input not ready straight after reset");

    // points of one frame follow back to back and share the speed byte
    a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[52:45] == $past(m_tdata[52:45])))
        else $error("point run of a frame broken");

endmodule

bind lidar_frame_point_decoder_top lfpd_checker u_lfpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> dv/tb_lidar_frame_point_decoder_top.sv
module tb_lidar_frame_point_decoder_top;
    import lfpd_pkg::*;

    localparam int ANGLE_BIAS   = 327680;
    localparam int TURN_UNITS   = 184320;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 50;
    localparam int BODY_FULL    = FRAME_BYTES - 4;

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

    class point_scoreboard;
        typedef struct {
            logic [ANGLE_W-1:0] angle;
            logic [DIST_W-1:0]  distance;
            logic [7:0]         quality;
            logic [7:0]         speed;
            logic               last;
        } point_t;

        logic [4:0] pos;
        logic [7:0] frame_store [FRAME_BYTES];
        point_t     points_due [$];
        int         errors;

        function new();
            pos = POS_HUNT;
            errors = 0;
        endfunction

        function int pending();
            return points_due.size();
        endfunction

        // walk the header hunt; queue eight points when byte 31 lands
        function void note_byte(logic [7:0] b);
            int     first_ang;
            int     last_ang;
            int     stride;
            int     ang;
            int     base;
            point_t p;
            case (pos)
                POS_HUNT:  if (b == HDR_A) pos = POS_HDR_B;
                POS_HDR_B: pos = (b == HDR_B) ? POS_SPEED : POS_HUNT;
                POS_SPEED:
                begin
                    frame_store[POS_SPEED] = b;
                    pos = POS_HDR_C;
                end
                POS_HDR_C: pos = (b == HDR_C) ? POS_FIRST : POS_HUNT;
                default:
                begin
                    frame_store[pos] = b;
                    if (pos != POS_LAST)
                    begin
                        pos = pos + 5'd1;
                    end
                    else
                    begin
                        pos = POS_HUNT;
                        first_ang = int'({frame_store[5], frame_store[4]});
                        last_ang  = int'({frame_store[31], frame_store[30]});
                        first_ang = first_ang * 8 - ANGLE_BIAS;
                        last_ang  = last_ang * 8 - ANGLE_BIAS;
                        if (last_ang < first_ang)
                            last_ang += TURN_UNITS;
                        stride = (last_ang - first_ang) / POINTS;
                        for (int k = 0; k < POINTS; k++)
                        begin
                            ang  = first_ang + stride * k;
                            base = POINT_BASE + POINT_BYTES * k;
                            p.angle    = ang[ANGLE_W-1:0];
                            p.distance = {frame_store[base + 1], frame_store[base]};
                            p.quality  = frame_store[base + 2];
                            p.speed    = frame_store[POS_SPEED];
                            p.last     = (k == POINTS - 1);
                            points_due.push_back(p);
                        end
                    end
                end
            endcase
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, exp_v, act_v);
        endfunction

        function void check_point(logic [OUT_TDATA_W-1:0] word, logic last);
            point_t p;
            if (points_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected point word, expected none, actual %0h last %0b",
                         $time, word, last);
                return;
            end
            p = points_due.pop_front();
            if (word[20:0] !== p.angle)
                report("point_angle", 32'(p.angle), 32'(word[20:0]));
            if (word[36:21] !== p.distance)
                report("point_distance", 32'(p.distance), 32'(word[36:21]));
            if (word[44:37] !== p.quality)
                report("point_quality", 32'(p.quality), 32'(word[44:37]));
            if (word[52:45] !== p.speed)
                report("rotation_speed", 32'(p.speed), 32'(word[52:45]));
            if (word[55:53] !== 3'b000)
                report("pad bits", 32'd0, 32'(word[55:53]));
            if (last !== p.last)
                report("last_point", 32'(p.last), 32'(last));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    point_scoreboard sb = new();
    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    bit  hold_req = 1'b0;

    lidar_frame_point_decoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sb.note_byte(b);
    endtask

    // body_len counts the stored bytes after the 0x4E; short values truncate the frame
    task automatic send_frame(input logic [7:0] speed, input logic [15:0] start_raw,
                              input logic [15:0] end_raw, input fill_t fill,
                              input int body_len);
        logic [7:0] b;
        send_byte(HDR_A);
        send_byte(HDR_B);
        send_byte(speed);
        send_byte(HDR_C);
        for (int i = POS_FIRST; i < POS_FIRST + body_len; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            if (i == 4)  b = start_raw[7:0];
            if (i == 5)  b = start_raw[15:8];
            if (i == 30) b = end_raw[7:0];
            if (i == 31) b = end_raw[15:8];
            send_byte(b);
        end
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        int         pick;
        logic [7:0] bad;
        logic [15:0] a0;
        logic [15:0] a1;
        pick = $urandom_range(99);
        a0 = pick_raw();
        a1 = ($urandom_range(9) == 0) ? a0 : pick_raw();
        if (pick < 8)
        begin
            do bad = 8'($urandom); while (bad == HDR_B);
            send_byte(HDR_A);
            send_byte(bad);
        end
        else if (pick < 14)
        begin
            do bad = 8'($urandom); while (bad == HDR_C);
            send_byte(HDR_A);
            send_byte(HDR_B);
            send_byte(8'($urandom));
            send_byte(bad);
        end
        else if (pick < 20)
        begin
            send_frame(8'($urandom), a0, a1, FILL_RAND, $urandom_range(BODY_FULL - 1));
        end
        else
        begin
            send_frame(8'($urandom), a0, a1, FILL_RAND, BODY_FULL);
        end
        // checksum and tail, hunted over
        repeat ($urandom_range(3)) send_byte(8'($urandom));
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // receiver: check each accepted word, then pick the next tready
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_point(m_tdata, m_tlast);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 22;
        snk_idle_pct = 61;

        // noise while hunting, then a header byte that fails and is not rechecked
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_C);
        send_byte(HDR_B);
        send_byte(HDR_A);
        send_byte(HDR_A);
        send_byte(HDR_B);
        send_byte(8'h55);
        send_byte(HDR_C);
        // bad third header byte
        send_byte(HDR_A);
        send_byte(HDR_B);
        send_byte(8'hAA);
        send_byte(HDR_C ^ 8'h01);

        send_frame(8'h00, 16'h0000, 16'hFFFF, FILL_ZERO, BODY_FULL);
        send_frame(8'hFF, 16'hFFFF, 16'h0000, FILL_ONES, BODY_FULL);
        send_frame(8'h5A, 16'h1234, 16'h1234, FILL_RAND, BODY_FULL);
        send_frame(8'hA5, 16'h8000, 16'h7FFF, FILL_RAND, BODY_FULL);

        repeat (2) send_random_frame();

        // pause the stream until every point has come out
        s_tvalid <= 1'b0;
        wait_drained();

        src_idle_pct = 61;
        snk_idle_pct = 22;
        repeat (2) send_random_frame();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        // hold the output long enough to fill the frame queue and stall the input
        hold_req = 1'b1;
        repeat (4) send_frame(8'($urandom), pick_raw(), pick_raw(), FILL_RAND, BODY_FULL);
        send_random_frame();

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
